/* rtl/utod_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UCS-4 decoder package
// Shared types, queue sizing and the byte group decode function.
// ----------------------------------------------------------------------------
package utod_pkg;

  // Output queue sizing. The depth must be a power of two so that the
  // pointers wrap naturally.
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  // Field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 31;
  localparam int unsigned TailW   = 30;
  localparam int unsigned CountW  = 3;

  // Byte classification and decode constants.
  localparam logic [1:0]        ContTag      = 2'b10;
  localparam logic [CountW-1:0] CountMax     = 3'd7;
  localparam logic [CpW-1:0]    OverlongCode = 31'h0000_0020;

  // One result word: a code point and its end-of-string mark.
  typedef struct packed {
    logic           last;
    logic [CpW-1:0] cp;
  } result_t;

  // Results produced by one accepted byte, at most two.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Decode one byte group from its lead byte, tail bits and byte count.
  function automatic logic [CpW-1:0] decode_group(
    input logic [ByteW-1:0]  lead,
    input logic [TailW-1:0]  tail,
    input logic [CountW-1:0] cnt
  );
    logic [CpW-1:0] v;
    unique case (cnt)
      3'd1:    v = {24'd0, lead[6:0]};
      3'd2:    v = {20'd0, lead[4:0], tail[5:0]};
      3'd3:    v = {15'd0, lead[3:0], tail[11:0]};
      3'd4:    v = {10'd0, lead[2:0], tail[17:0]};
      3'd5:    v = {5'd0, lead[1:0], tail[23:0]};
      3'd6:    v = {lead[0], tail[29:0]};
      default: v = OverlongCode;
    endcase
    return v;
  endfunction

endpackage

/* rtl/utod_out_fifo.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder output queue
// Small register queue that takes up to two result words per cycle and
// hands out one word per cycle while the master stream side is ready.
// ----------------------------------------------------------------------------
module utod_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  utod_pkg::push_t   push_i,
  output logic              room_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output utod_pkg::result_t m_data_o
);

  utod_pkg::result_t                mem_q [utod_pkg::QDepth];
  logic [utod_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [utod_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [utod_pkg::QCntW-1:0]       count_q, count_d;
  logic [utod_pkg::QPtrW-1:0]       wr_ptr_nx;
  logic                             pop;

  // Room for a worst-case byte, which produces two words.
  assign room_o    = count_q <= utod_pkg::QCntW'(utod_pkg::QDepth - 2);
  assign m_valid_o = count_q != '0;
  assign m_data_o  = mem_q[rd_ptr_q];
  assign pop       = m_valid_o && m_ready_i;

  // The second slot wraps with the pointer since the depth is a power of two.
  assign wr_ptr_nx = wr_ptr_q + utod_pkg::QPtrW'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + utod_pkg::QPtrW'(push_i.n);
    rd_ptr_d = rd_ptr_q + utod_pkg::QPtrW'(pop);
    count_d  = count_q + utod_pkg::QCntW'(push_i.n) - utod_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage, written at up to two consecutive slots.
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

endmodule

/* rtl/utf8_to_ucs4_stream_decoder.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UCS-4 stream decoder
// Decodes UTF-8 byte groups to UCS-4; groups over six bytes give 0x20.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one string byte per word in tdata; tlast marks
//   the last byte before the terminator. The master stream carries one code
//   point per word in tdata[30:0]; tlast marks the final code point of the
//   string. A group is closed when a non-continuation byte arrives or when
//   the string ends, so its code point is written to the output queue as
//   the closing byte is accepted. Throughput is one byte per cycle while
//   tready is high. A byte that both closes a group and ends the string
//   yields two words; these drain from a four-entry output queue at one
//   word per cycle while the receiver is ready. The slave side is ready
//   whenever the queue has two free entries, which is the rate limit under
//   a stalled receiver. When the receiver stalls, the queue fills and tready
//   drops until words are taken; nothing is lost. Reset empties the queue
//   and closes any open group, so the next byte starts a new string.
// ----------------------------------------------------------------------------
module utf8_to_ucs4_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  input  logic        s_axis_tlast_i,   // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [30:0] codepoint, [31] zero fill
  output logic        m_axis_tlast_o    // string_last
);

  logic                           open_q, open_d;
  logic [utod_pkg::ByteW-1:0]     lead_q, lead_d;
  logic [utod_pkg::TailW-1:0]     tail_q, tail_d;
  logic [utod_pkg::CountW-1:0]    cnt_q, cnt_d;
  logic                           accept;
  logic                           room;
  logic                           is_cont;
  logic [utod_pkg::ByteW-1:0]     lead_g;
  logic [utod_pkg::TailW-1:0]     tail_g;
  logic [utod_pkg::CountW-1:0]    cnt_g;
  utod_pkg::push_t                push;
  utod_pkg::result_t              out_word;

  assign s_axis_tready_o = room;
  assign accept  = s_axis_tvalid_i && room;
  assign is_cont = open_q && (s_axis_tdata_i[7:6] == utod_pkg::ContTag);

  // Group state after the byte is added, before any end-of-string flush.
  always_comb begin
    if (is_cont) begin
      lead_g = lead_q;
      tail_g = {tail_q[utod_pkg::TailW-7:0], s_axis_tdata_i[5:0]};
      cnt_g  = (cnt_q < utod_pkg::CountMax) ? cnt_q + 3'd1 : cnt_q;
    end else begin
      lead_g = s_axis_tdata_i;
      tail_g = '0;
      cnt_g  = 3'd1;
    end
  end

  // Result words caused by this byte: a closed group, then a flush.
  always_comb begin
    push      = '0;
    push.r0.cp = utod_pkg::decode_group(lead_q, tail_q, cnt_q);
    push.r1.cp = utod_pkg::decode_group(lead_g, tail_g, cnt_g);
    push.r1.last = 1'b1;
    if (accept) begin
      if (!is_cont && open_q) begin
        push.n = s_axis_tlast_i ? 2'd2 : 2'd1;
      end else if (s_axis_tlast_i) begin
        push.n  = 2'd1;
        push.r0 = push.r1;
      end
    end
  end

  // Next group state; the end of a string closes everything.
  always_comb begin
    open_d = open_q;
    lead_d = lead_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (s_axis_tlast_i) begin
        open_d = 1'b0;
        lead_d = '0;
        tail_d = '0;
        cnt_d  = '0;
      end else begin
        open_d = 1'b1;
        lead_d = lead_g;
        tail_d = tail_g;
        cnt_d  = cnt_g;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      lead_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      open_q <= open_d;
      lead_q <= lead_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Output queue toward the master stream.
  utod_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .room_o    (room),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (out_word)
  );

  assign m_axis_tdata_o = {1'b0, out_word.cp};
  assign m_axis_tlast_o = out_word.last;

endmodule

/* rtl/utod_checker.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Concurrent checks on the top level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module utod_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // A pending word stays offered until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word withdrawn before it was taken");

  // A stalled word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output word changed");

  // The end of a string always leaves at least one word to deliver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("string end produced no output word");

  // Code points are 31 bits wide; the fill bit stays clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[31])
    else $error("code point fill bit set");

endmodule

bind utf8_to_ucs4_stream_decoder utod_checker u_utod_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
